// ----- hw/rtl/radix_converter_defines.svh -----
// assertion macros shared by the rtl
`ifndef RADIX_CONVERTER_DEFINES_SVH
`define RADIX_CONVERTER_DEFINES_SVH

`ifndef SYNTHESIS
`define RC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("radix_converter: check failed");
`define RC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("radix_converter: check failed");
`else
`define RC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- hw/rtl/rc_pkg.sv -----
package rc_pkg;

    localparam int MAG_BITS  = 63;
    localparam int CHAR_W    = 8;
    localparam int BASE_W    = 5;
    localparam int DIGIT_W   = 4;
    localparam int SUM_W     = MAG_BITS + BASE_W;
    localparam int LO_W      = MAG_BITS / 2;
    localparam int HI_W      = MAG_BITS - LO_W;
    localparam int DIV_BITS  = 8;
    localparam int DIV_W     = ((MAG_BITS + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
    localparam int DIV_STEPS = DIV_W / DIV_BITS;
    localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
    localparam int BUF_DEPTH = 64;
    localparam int IDX_W     = $clog2(BUF_DEPTH);
    localparam int CNT_W     = IDX_W + 1;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_BASE = 1'd1;

    localparam logic [BASE_W-1:0] SOURCE_BASE_RST = 5'd10;
    localparam logic [BASE_W-1:0] TARGET_BASE_RST = 5'd2;
    localparam logic [BASE_W-1:0] BASE_MIN        = 5'd2;
    localparam logic [BASE_W-1:0] BASE_MAX        = 5'd16;
    localparam logic [BASE_W-1:0] DIGIT_INVALID   = 5'd16;

    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_A     = 8'h41;
    localparam logic [CHAR_W-1:0] CH_F     = 8'h46;
    localparam logic [CHAR_W-1:0] CH_NONE  = 8'h00;

    typedef struct packed {
        logic load;
        logic add;
        logic div;
        logic div_store;
        logic emit_sign;
        logic rd_load;
        logic rd;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic res_err;
        logic quo_zero;
        logic neg_out;
        logic idx_zero;
    } t_status;

    function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
        logic [BASE_W-1:0] r;
        r = b;
        if (b < BASE_MIN) r = BASE_MIN;
        if (b > BASE_MAX) r = BASE_MAX;
        return r;
    endfunction

    function automatic logic [BASE_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] off;
        logic [BASE_W-1:0] r;
        r   = DIGIT_INVALID;
        off = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            off = c - CH_ZERO;
            r   = {1'b0, off[DIGIT_W-1:0]};
        end else if (c >= CH_A && c <= CH_F) begin
            off = c - CH_A;
            r   = 5'd10 + {1'b0, off[DIGIT_W-1:0]};
        end
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] r;
        if (d < 4'd10) begin
            r = CH_ZERO + {4'b0, d};
        end else begin
            r = CH_A + {4'b0, d} - 8'd10;
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/rc_ctrl.sv -----
module rc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  rc_pkg::t_status i_stat,
    output logic           o_busy,
    output rc_pkg::t_cmd   o_cmd
);
    import rc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_DIV,
        S_DCHK,
        S_READ
    } t_state;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_busy;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_step    = '0;
                if (i_stat.last && !i_stat.res_err) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                o_cmd.div       = 1'b1;
                o_cmd.div_store = (r_step == STEP_LAST);
                n_step          = r_step + 1'b1;
                if (r_step == STEP_LAST) begin
                    n_state = S_DCHK;
                end
            end
            S_DCHK: begin
                n_step = '0;
                if (i_stat.quo_zero) begin
                    o_cmd.rd_load   = 1'b1;
                    o_cmd.emit_sign = i_stat.neg_out;
                    n_state         = S_READ;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                if (i_stat.idx_zero) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_busy = r_busy;

endmodule

// ----- hw/rtl/rc_dp.sv -----
module rc_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rc_pkg::t_cmd                i_cmd,
    input  logic [rc_pkg::CHAR_W-1:0]   i_char_in,
    input  logic                        i_last_in,
    input  logic [rc_pkg::BASE_W-1:0]   i_source_base,
    input  logic [rc_pkg::BASE_W-1:0]   i_target_base,
    output rc_pkg::t_status             o_stat,
    output logic                        o_strobe,
    output logic [rc_pkg::CHAR_W-1:0]   o_char_out,
    output logic                        o_status,
    output logic                        o_last_out
);
    import rc_pkg::*;

    // number being assembled
    logic [MAG_BITS-1:0]       r_acc, n_acc;
    logic                      r_neg, n_neg;
    logic                      r_err, n_err;
    logic                      r_seen, n_seen;
    logic [CHAR_W-1:0]         r_char;
    logic                      r_last;
    logic [LO_W+BASE_W-1:0]    r_p_lo;
    logic [HI_W+BASE_W-1:0]    r_p_hi;

    // conversion
    logic [DIV_W-1:0]          r_quo, n_quo;
    logic [DIGIT_W-1:0]        r_rem, n_rem;
    logic [CNT_W-1:0]          r_cnt;
    logic [IDX_W-1:0]          r_idx;
    logic                      r_neg_out;
    logic [DIGIT_W-1:0]        r_mem [BUF_DEPTH];
    logic [DIGIT_W-1:0]        r_mem_q;
    logic                      r_rd_v;
    logic                      r_rd_last;

    // result register
    logic                      r_out_v;
    logic [CHAR_W-1:0]         r_out_char;
    logic                      r_out_status;
    logic                      r_out_last;

    logic [BASE_W-1:0]         src_base;
    logic [BASE_W-1:0]         tgt_base;
    logic [BASE_W-1:0]         dval;
    logic [SUM_W-1:0]          sum;
    logic                      ovf;
    logic                      first;
    logic                      res_err;
    logic                      emit_err;
    logic [DIV_BITS-1:0]       q_bits;
    logic [BASE_W-1:0]         trial;

    assign src_base = clamp_base(i_source_base);
    assign tgt_base = clamp_base(i_target_base);
    assign dval     = digit_value(r_char);
    assign first    = !r_seen && !r_neg && !r_err;
    assign sum      = {r_p_hi, {LO_W{1'b0}}} + SUM_W'(r_p_lo) + SUM_W'(dval);
    assign ovf      = |sum[SUM_W-1:MAG_BITS];

    always_comb begin
        n_acc  = r_acc;
        n_neg  = r_neg;
        n_err  = r_err;
        n_seen = r_seen;
        if (!r_err) begin
            if (first && r_char == CH_MINUS) begin
                n_neg = 1'b1;
            end else if (dval >= src_base) begin
                n_err = 1'b1;
            end else if (ovf) begin
                n_err = 1'b1;
            end else begin
                n_acc  = sum[MAG_BITS-1:0];
                n_seen = 1'b1;
            end
        end
    end

    assign res_err  = n_err || !n_seen;
    assign emit_err = i_cmd.add && r_last && res_err;

    // restoring division, one byte of the dividend per cycle while div is set
    always_comb begin
        n_rem  = r_rem;
        q_bits = '0;
        trial  = '0;
        for (int k = 0; k < DIV_BITS; k++) begin
            trial = {n_rem, r_quo[DIV_W-1-k]};
            if (trial >= tgt_base) begin
                q_bits[DIV_BITS-1-k] = 1'b1;
                n_rem = DIGIT_W'(trial - tgt_base);
            end else begin
                n_rem = trial[DIGIT_W-1:0];
            end
        end
        n_quo = DIV_W'({r_quo, q_bits});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_err   <= 1'b0;
            r_seen  <= 1'b0;
            r_rd_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (i_cmd.add) begin
                if (r_last) begin
                    r_acc  <= '0;
                    r_neg  <= 1'b0;
                    r_err  <= 1'b0;
                    r_seen <= 1'b0;
                end else begin
                    r_acc  <= n_acc;
                    r_neg  <= n_neg;
                    r_err  <= n_err;
                    r_seen <= n_seen;
                end
            end
            r_rd_v  <= i_cmd.rd;
            r_out_v <= emit_err || i_cmd.emit_sign || r_rd_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_char <= i_char_in;
            r_last <= i_last_in;
            r_p_lo <= (LO_W+BASE_W)'(r_acc[LO_W-1:0]) * (LO_W+BASE_W)'(src_base);
            r_p_hi <= (HI_W+BASE_W)'(r_acc[MAG_BITS-1:LO_W]) * (HI_W+BASE_W)'(src_base);
        end
        if (i_cmd.add && r_last && !res_err) begin
            r_quo     <= DIV_W'(n_acc);
            r_rem     <= '0;
            r_cnt     <= '0;
            r_neg_out <= n_neg && (n_acc != '0);
        end
        if (i_cmd.div) begin
            r_quo <= n_quo;
            if (i_cmd.div_store) begin
                r_rem <= '0;
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_rem <= n_rem;
            end
        end
        if (i_cmd.rd_load) begin
            r_idx <= r_cnt[IDX_W-1:0] - 1'b1;
        end
        if (i_cmd.rd) begin
            r_idx     <= r_idx - 1'b1;
            r_rd_last <= (r_idx == '0);
        end
        if (emit_err) begin
            r_out_char   <= CH_NONE;
            r_out_status <= 1'b1;
            r_out_last   <= 1'b1;
        end else if (i_cmd.emit_sign) begin
            r_out_char   <= CH_MINUS;
            r_out_status <= 1'b0;
            r_out_last   <= 1'b0;
        end else if (r_rd_v) begin
            r_out_char   <= digit_char(r_mem_q);
            r_out_status <= 1'b0;
            r_out_last   <= r_rd_last;
        end
    end

    // digit buffer, least significant digit at entry zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.div && i_cmd.div_store) begin
            r_mem[r_cnt[IDX_W-1:0]] <= n_rem;
        end
        if (i_cmd.rd) begin
            r_mem_q <= r_mem[r_idx];
        end
    end

    assign o_stat.last     = r_last;
    assign o_stat.res_err  = res_err;
    assign o_stat.quo_zero = (r_quo == '0);
    assign o_stat.neg_out  = r_neg_out;
    assign o_stat.idx_zero = (r_idx == '0);

    assign o_strobe   = r_out_v;
    assign o_char_out = r_out_char;
    assign o_status   = r_out_status;
    assign o_last_out = r_out_last;

endmodule

// ----- hw/rtl/radix_converter.sv -----
// Radix converter. Characters of a signed number (optional leading '-', digits 0-9 and A-F,
// each below source_base) are fed one per request with start while busy is low; the one
// marked i_last_in ends the number. For each character the accept edge registers the two
// halves of magnitude * base, the next cycle does the add and the overflow check. On the
// last character busy stays high while the magnitude is divided by target_base, 8 dividend
// bits per cycle in S_DIV, each output digit taking the DIV_STEPS division steps and then
// an S_DCHK check; the digits then leave at one result per cycle, a '-' first for a
// negative non-zero value, the last result flagged by o_last_out. A malformed number, a
// lone '-' or a magnitude beyond 63 bits gives a single result with o_status high. Results
// are shown for one cycle with o_strobe and cannot be held off by the receiver. Base
// registers are written through the cfg port (always ready); the user must write them
// only while busy is low, as the block itself does not enforce it. A base below 2 acts as
// 2 and above 16 as 16. The digit buffer needs no clearing after reset.
`include "radix_converter_defines.svh"

module radix_converter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [rc_pkg::CHAR_W-1:0]     i_char_in,
    input  logic                          i_last_in,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rc_pkg::BASE_W-1:0]     i_cfg_data,
    output logic                          o_strobe,
    output logic [rc_pkg::CHAR_W-1:0]     o_char_out,
    output logic                          o_status,
    output logic                          o_last_out
);
    import rc_pkg::*;

    logic [BASE_W-1:0] r_source_base;
    logic [BASE_W-1:0] r_target_base;
    t_cmd              cmd;
    t_status           stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_base <= SOURCE_BASE_RST;
            r_target_base <= TARGET_BASE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SOURCE_BASE: r_source_base <= i_cfg_data;
                CFG_TARGET_BASE: r_target_base <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    rc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    rc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_char_in     (i_char_in),
        .i_last_in     (i_last_in),
        .i_source_base (r_source_base),
        .i_target_base (r_target_base),
        .o_stat        (stat),
        .o_strobe      (o_strobe),
        .o_char_out    (o_char_out),
        .o_status      (o_status),
        .o_last_out    (o_last_out)
    );

    // an error result always closes its number and leaves the block idle
    `RC_ASSERT_IMP(a_err_is_last, i_clk, i_rst_n, o_strobe && o_status, o_last_out && !busy)
    // a character that does not end its number never causes a result
    `RC_ASSERT_IMP(a_no_result_mid, i_clk, i_rst_n, $past(start && !busy && !i_last_in, 2), !o_strobe)
    // a sign is never the final result of a number
    `RC_ASSERT_IMP(a_sign_first, i_clk, i_rst_n, o_strobe && o_char_out == CH_MINUS, !o_last_out)

endmodule
